### hdl/accounting_session_map_table_defines.svh
// Assertion macros for the checker.
`ifndef ACCOUNTING_SESSION_MAP_TABLE_DEFINES_SVH
`define ACCOUNTING_SESSION_MAP_TABLE_DEFINES_SVH

// Implication checked in the same cycle.
`define ASMT_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) else $error(msg);

// Implication checked in the next cycle.
`define ASMT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) else $error(msg);

`endif

### hdl/asmt_pkg.sv
// Shared types and constants of the accounting session map table.
`timescale 1ns / 1ps
`default_nettype none
package asmt_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int ADDR_W = 32;
    localparam int SESS_W = 64;
    localparam int NUM_W  = 60;

    localparam logic [7:0] CODE_ACCT    = 8'h04;
    localparam logic [1:0] STATUS_START = 2'd1;
    localparam logic [1:0] STATUS_STOP  = 2'd2;
    localparam logic       CMD_LOOKUP   = 1'b1;

    typedef enum logic [3:0] {
        OC_NOT_ACCT  = 4'd0,
        OC_MISSING   = 4'd1,
        OC_ADDED     = 4'd2,
        OC_DUPLICATE = 4'd3,
        OC_REMOVED   = 4'd4,
        OC_NOT_FOUND = 4'd5,
        OC_UNKNOWN   = 4'd6,
        OC_HIT       = 4'd7,
        OC_MISS      = 4'd8,
        OC_FULL      = 4'd9
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SELECT,
        ST_READ,
        ST_OLD,
        ST_DONE
    } state_t;

    // Per-slot write strobes
    typedef struct packed {
        logic num_set;
        logic num_clr;
        logic sess_set;
        logic sess_clr;
        logic cli_set;
    } cell_wr_t;

    // Per-slot valid and match flags
    typedef struct packed {
        logic nv;
        logic sv;
        logic cv;
        logic nm;
        logic sm;
        logic cm;
    } cell_flags_t;

    // Readout bus passed along the row of slots
    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [ADDR_W-1:0] addr;
        logic [SESS_W-1:0] sess;
    } cell_rd_t;

endpackage
`default_nettype wire

### hdl/asmt_cell.sv
// One slot of all three maps, with compare logic and a readout pass-through.
`timescale 1ns / 1ps
`default_nettype none
module asmt_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [asmt_pkg::ADDR_W-1:0] key_addr,
    input  wire logic [asmt_pkg::SESS_W-1:0] key_sess,
    input  wire logic [asmt_pkg::NUM_W-1:0]  wr_num,
    input  wire asmt_pkg::cell_wr_t          wr,
    input  wire logic                        sel_n,
    input  wire logic                        sel_s,
    input  wire logic                        sel_c,
    input  wire asmt_pkg::cell_rd_t          rd_in,
    output asmt_pkg::cell_rd_t               rd_out,
    output asmt_pkg::cell_flags_t            flags
);

    logic nv_reg, sv_reg, cv_reg;
    logic nv_next, sv_next, cv_next;
    logic [asmt_pkg::ADDR_W-1:0] n_addr_reg, s_addr_reg, c_addr_reg;
    logic [asmt_pkg::NUM_W-1:0]  n_val_reg;
    logic [asmt_pkg::SESS_W-1:0] s_key_reg, c_sess_reg;

    // Valid bits: set wins over clear
    always_comb begin
        nv_next = wr.num_set ? 1'b1 : (wr.num_clr ? 1'b0 : nv_reg);
        sv_next = wr.sess_set ? 1'b1 : (wr.sess_clr ? 1'b0 : sv_reg);
        cv_next = wr.cli_set ? 1'b1 : cv_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 1'b0;
            sv_reg <= 1'b0;
            cv_reg <= 1'b0;
        end else begin
            nv_reg <= nv_next;
            sv_reg <= sv_next;
            cv_reg <= cv_next;
        end
    end

    // Store entry contents
    always_ff @(posedge aclk) begin
        if (wr.num_set) begin
            n_addr_reg <= key_addr;
            n_val_reg  <= wr_num;
        end
        if (wr.sess_set) begin
            s_key_reg  <= key_sess;
            s_addr_reg <= key_addr;
        end
        if (wr.cli_set) begin
            c_addr_reg <= key_addr;
            c_sess_reg <= key_sess;
        end
    end

    // Compare against the search keys
    always_comb begin
        flags.nv = nv_reg;
        flags.sv = sv_reg;
        flags.cv = cv_reg;
        flags.nm = nv_reg && (n_addr_reg == key_addr);
        flags.sm = sv_reg && (s_key_reg == key_sess);
        flags.cm = cv_reg && (c_addr_reg == key_addr);
    end

    // Merge the selected entry into the readout bus
    always_comb begin
        rd_out.num  = rd_in.num  | (sel_n ? n_val_reg  : '0);
        rd_out.addr = rd_in.addr | (sel_s ? s_addr_reg : '0);
        rd_out.sess = rd_in.sess | (sel_c ? c_sess_reg : '0);
    end

endmodule
`default_nettype wire

### hdl/accounting_session_map_table.sv
// Top level: sequencer over a row of map slots.
// The sequencer handles one item at a time (match, select, read, second search, update)
// and accepts a new item only when idle and the result register is free or being taken.
// The second search for an older session reuses the slot compare units.
// Reset: aresetn (synchronous, active low) clears all valid bits and control state.
`timescale 1ns / 1ps
`default_nettype none
module accounting_session_map_table #(
    parameter int TABLE_ENTRIES = asmt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [0] cmd
    input  wire logic         s_tuser,
    // [7:0] packet_code, [9:8] status_kind, [10] session_present,
    // [74:11] session_key, [75] address_present, [107:76] client_address,
    // [108] number_present, [168:109] subscriber_number, [175:169] zero
    input  wire logic [175:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [0] forward_request, [4:1] outcome, [64:5] found_number, [71:65] zero
    output logic [71:0]       m_tdata
);

    localparam int N = TABLE_ENTRIES;
    localparam logic [N-1:0] ONE = N'(1);

    asmt_pkg::state_t state_reg, state_next;

    logic                        cmd_reg, sess_p_reg, addr_p_reg, num_p_reg;
    logic [7:0]                  code_reg;
    logic [1:0]                  status_reg;
    logic [asmt_pkg::SESS_W-1:0] sess_reg;
    logic [asmt_pkg::ADDR_W-1:0] addr_reg;
    logic [asmt_pkg::NUM_W-1:0]  num_reg;

    logic [N-1:0] nv_vec, sv_vec, cv_vec, nm_vec, sm_vec, cm_vec;
    logic [N-1:0] nv_reg, sv_reg, cv_reg, nm_reg, sm_reg, cm_reg;
    logic [N-1:0] n_oh_reg, s_oh_reg, c_oh_reg, old_oh_reg, old_oh_next;
    logic [asmt_pkg::NUM_W-1:0]  n_val_reg;
    logic [asmt_pkg::ADDR_W-1:0] s_addr_reg;
    logic [asmt_pkg::SESS_W-1:0] c_sess_reg;
    logic [asmt_pkg::SESS_W-1:0] key_sess;

    logic [N-1:0] num_set_vec, num_clr_vec, sess_set_vec, sess_clr_vec, cli_set_vec;
    logic [N-1:0] nf_oh, sf_oh, cf_oh, sfree, cfree;
    logic         fwd_next;
    asmt_pkg::outcome_t oc_next;
    logic [asmt_pkg::NUM_W-1:0] found_next;
    logic         do_write;

    logic                        m_fwd_reg;
    asmt_pkg::outcome_t          m_oc_reg;
    logic [asmt_pkg::NUM_W-1:0]  m_num_reg;
    logic                        m_tvalid_reg;

    asmt_pkg::cell_rd_t rd_chain [0:N];
    logic n_hit, s_hit, c_hit;

    // Row of slots, readout handed from slot to slot
    assign rd_chain[0] = '0;
    assign key_sess = (state_reg == asmt_pkg::ST_OLD) ? c_sess_reg : sess_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        asmt_pkg::cell_wr_t    wr;
        asmt_pkg::cell_flags_t fl;
        always_comb begin
            wr.num_set  = do_write && num_set_vec[i];
            wr.num_clr  = do_write && num_clr_vec[i];
            wr.sess_set = do_write && sess_set_vec[i];
            wr.sess_clr = do_write && sess_clr_vec[i];
            wr.cli_set  = do_write && cli_set_vec[i];
        end
        asmt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .key_addr (addr_reg),
            .key_sess (key_sess),
            .wr_num   (num_reg),
            .wr       (wr),
            .sel_n    (n_oh_reg[i]),
            .sel_s    (s_oh_reg[i]),
            .sel_c    (c_oh_reg[i]),
            .rd_in    (rd_chain[i]),
            .rd_out   (rd_chain[i+1]),
            .flags    (fl)
        );
        assign nv_vec[i] = fl.nv;
        assign sv_vec[i] = fl.sv;
        assign cv_vec[i] = fl.cv;
        assign nm_vec[i] = fl.nm;
        assign sm_vec[i] = fl.sm;
        assign cm_vec[i] = fl.cm;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asmt_pkg::ST_IDLE:   if (s_tvalid && s_tready) state_next = asmt_pkg::ST_MATCH;
            asmt_pkg::ST_MATCH:  state_next = asmt_pkg::ST_SELECT;
            asmt_pkg::ST_SELECT: state_next = asmt_pkg::ST_READ;
            asmt_pkg::ST_READ:   state_next = asmt_pkg::ST_OLD;
            asmt_pkg::ST_OLD:    state_next = asmt_pkg::ST_DONE;
            asmt_pkg::ST_DONE:   state_next = asmt_pkg::ST_IDLE;
            default:             state_next = asmt_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready = 1'b0;
        do_write = 1'b0;
        case (state_reg)
            asmt_pkg::ST_IDLE: s_tready = !m_tvalid_reg || m_tready;
            asmt_pkg::ST_DONE: do_write = 1'b1;
            default: begin
                s_tready = 1'b0;
                do_write = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= asmt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the item
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg    <= s_tuser;
            code_reg   <= s_tdata[7:0];
            status_reg <= s_tdata[9:8];
            sess_p_reg <= s_tdata[10];
            sess_reg   <= s_tdata[74:11];
            addr_p_reg <= s_tdata[75];
            addr_reg   <= s_tdata[107:76];
            num_p_reg  <= s_tdata[108];
            num_reg    <= s_tdata[168:109];
        end
    end

    // Older session search: lowest match, only when it differs from the new one
    assign old_oh_next = (sm_vec & (~sm_vec + ONE))
                         & {N{c_hit && (c_sess_reg != sess_reg)}};

    // Search pipeline
    always_ff @(posedge aclk) begin
        case (state_reg)
            asmt_pkg::ST_MATCH: begin
                nv_reg <= nv_vec;
                sv_reg <= sv_vec;
                cv_reg <= cv_vec;
                nm_reg <= nm_vec;
                sm_reg <= sm_vec;
                cm_reg <= cm_vec;
            end
            asmt_pkg::ST_SELECT: begin
                n_oh_reg <= nm_reg & (~nm_reg + ONE);
                s_oh_reg <= sm_reg & (~sm_reg + ONE);
                c_oh_reg <= cm_reg & (~cm_reg + ONE);
            end
            asmt_pkg::ST_READ: begin
                n_val_reg  <= rd_chain[N].num;
                s_addr_reg <= rd_chain[N].addr;
                c_sess_reg <= rd_chain[N].sess;
            end
            asmt_pkg::ST_OLD: old_oh_reg <= old_oh_next;
            default: ;
        endcase
    end

    assign n_hit = |nm_reg;
    assign s_hit = |sm_reg;
    assign c_hit = |cm_reg;

    // Free slots for an insert
    assign sfree = ~(sv_reg & ~old_oh_reg);
    assign cfree = ~cv_reg;
    assign nf_oh = ~nv_reg & (nv_reg + ONE);
    assign sf_oh = sfree & (~sfree + ONE);
    assign cf_oh = c_hit ? c_oh_reg : (cfree & (~cfree + ONE));

    // Decide outcome and table updates
    always_comb begin
        fwd_next     = 1'b0;
        oc_next      = asmt_pkg::OC_UNKNOWN;
        found_next   = '0;
        num_set_vec  = '0;
        num_clr_vec  = '0;
        sess_set_vec = '0;
        sess_clr_vec = '0;
        cli_set_vec  = '0;
        if (cmd_reg == asmt_pkg::CMD_LOOKUP) begin
            if (addr_p_reg && n_hit) begin
                oc_next    = asmt_pkg::OC_HIT;
                found_next = n_val_reg;
            end else begin
                oc_next = asmt_pkg::OC_MISS;
            end
        end else if (code_reg != asmt_pkg::CODE_ACCT) begin
            oc_next = asmt_pkg::OC_NOT_ACCT;
        end else if (!addr_p_reg || !num_p_reg) begin
            fwd_next = 1'b1;
            oc_next  = asmt_pkg::OC_MISSING;
        end else if (status_reg == asmt_pkg::STATUS_START && sess_p_reg) begin
            if (n_hit || s_hit) begin
                oc_next = asmt_pkg::OC_DUPLICATE;
            end else if (nf_oh == '0 || sf_oh == '0 || cf_oh == '0) begin
                oc_next = asmt_pkg::OC_FULL;
            end else begin
                fwd_next     = 1'b1;
                oc_next      = asmt_pkg::OC_ADDED;
                num_set_vec  = nf_oh;
                sess_clr_vec = old_oh_reg;
                sess_set_vec = sf_oh;
                cli_set_vec  = cf_oh;
            end
        end else if (status_reg == asmt_pkg::STATUS_STOP) begin
            if (n_hit && sess_p_reg && s_hit && (s_addr_reg == addr_reg)) begin
                fwd_next    = 1'b1;
                oc_next     = asmt_pkg::OC_REMOVED;
                num_clr_vec = n_oh_reg;
            end else begin
                oc_next = asmt_pkg::OC_NOT_FOUND;
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (do_write) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            m_fwd_reg <= fwd_next;
            m_oc_reg  <= oc_next;
            m_num_reg <= found_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_num_reg, m_oc_reg, m_fwd_reg};

endmodule
`default_nettype wire

### hdl/asmt_checker.sv
// Port-level checker for the accounting session map table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "accounting_session_map_table_defines.svh"
module asmt_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata
);

    // Hold a stalled result
    `ASMT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
    // One item at a time: no accept right after an accept
    `ASMT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input accepted while busy")
    // Outcome code in range
    `ASMT_ASSERT_NOW(a_outcome, m_tvalid, m_tdata[4:1] <= asmt_pkg::OC_FULL, "outcome out of range")
    // Forwarding only on missing fields, added or removed
    `ASMT_ASSERT_NOW(a_fwd, m_tvalid && m_tdata[0], m_tdata[4:1] == asmt_pkg::OC_MISSING || m_tdata[4:1] == asmt_pkg::OC_ADDED || m_tdata[4:1] == asmt_pkg::OC_REMOVED, "forward with wrong outcome")
    // A number is returned only on a hit
    `ASMT_ASSERT_NOW(a_num, m_tvalid && (m_tdata[64:5] != 60'd0), m_tdata[4:1] == asmt_pkg::OC_HIT, "number without hit")

endmodule

bind accounting_session_map_table asmt_checker u_asmt_checker (.*);
`default_nettype wire
